>>> src/dhd_pkg.sv
// Shared types, constants and helper functions for the double-header deframer.
// Used by every module of the block; depends on nothing.
package dhd_pkg;

    // Frame layout.
    localparam int LENGTH_OFFSET = 2;
    localparam int LENGTH_DIGITS = 4;
    localparam int HEADER_SIZE   = 8;
    localparam int MAX_FRAME     = 1024;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 10;
    localparam int LEN_W   = 16;
    localparam int EV_W    = 3;

    // Width of the body length plus header size sum used for the completion test.
    localparam int LEN_SUM_W = LEN_W + 1;

    // Packed output word width, rounded up to whole bytes.
    localparam int RES_BITS  = BYTE_W + POS_W + LEN_W + 1;
    localparam int RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Event codes reported with each result.
    typedef enum logic [EV_W-1:0] {
        EV_DROP     = 3'd0,
        EV_STORE    = 3'd1,
        EV_RESYNC   = 3'd2,
        EV_DONE     = 3'd3,
        EV_OVERFLOW = 3'd4
    } t_event;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [POS_W-1:0]  position;
        t_event            event_res;
        logic [LEN_W-1:0]  body_length;
        logic              bad_digit;
    } t_result;

    // Decoded ASCII hex character.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // Maps an ASCII character to its hex value; anything else is zero and not ok.
    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] ch);
        t_hex        res;
        logic [7:0]  diff;
        res  = '0;
        diff = '0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            diff      = ch - 8'h30;
            res.ok    = 1'b1;
            res.value = diff[3:0];
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            diff      = ch - 8'h37;
            res.ok    = 1'b1;
            res.value = diff[3:0];
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            diff      = ch - 8'h57;
            res.ok    = 1'b1;
            res.value = diff[3:0];
        end
        return res;
    endfunction

endpackage

>>> src/dhd_parser.sv
// Frame parser state and per-byte decision logic of the deframer.
// Depends on dhd_pkg for layout constants, event codes and the result type.
module dhd_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [dhd_pkg::BYTE_W-1:0] i_byte,
    input  logic [dhd_pkg::BYTE_W-1:0] i_header,
    output dhd_pkg::t_result           o_result
);

    logic [dhd_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_sync, n_sync;
    logic                        r_last_hdr, n_last_hdr;
    logic [dhd_pkg::LEN_W-1:0]   r_acc, n_acc;
    logic [dhd_pkg::LEN_W-1:0]   r_len, n_len;
    logic                        r_err, n_err;
    logic                        r_latched, n_latched;

    logic                           is_header;
    logic                           is_full;
    logic                           in_field;
    logic [dhd_pkg::COUNT_W-1:0]    count_inc;
    logic [dhd_pkg::LEN_SUM_W-1:0]  done_sum;
    dhd_pkg::t_hex                  digit;

    assign is_header = (i_byte == i_header);
    assign is_full   = (r_count >= dhd_pkg::COUNT_W'(dhd_pkg::MAX_FRAME));
    assign count_inc = r_count + dhd_pkg::COUNT_W'(1);
    assign in_field  = (r_count >= dhd_pkg::COUNT_W'(dhd_pkg::LENGTH_OFFSET)) &&
                       (r_count < dhd_pkg::COUNT_W'(dhd_pkg::LENGTH_OFFSET +
                                                   dhd_pkg::LENGTH_DIGITS));
    assign digit     = dhd_pkg::hex_decode(i_byte);

    // Per-byte decision: next parser state and the result word.
    always_comb begin
        n_count    = r_count;
        n_sync     = r_sync;
        n_last_hdr = r_last_hdr;
        n_acc      = r_acc;
        n_len      = r_len;
        n_err      = r_err;
        n_latched  = r_latched;
        done_sum   = '0;

        o_result           = '0;
        o_result.byte_out  = i_byte;
        o_result.event_res = dhd_pkg::EV_DROP;

        priority if (is_header && r_last_hdr) begin
            // Doubled header: restart with both headers already stored.
            n_count            = dhd_pkg::COUNT_W'(2);
            n_sync             = 1'b1;
            n_last_hdr         = 1'b1;
            n_acc              = '0;
            n_len              = '0;
            n_err              = 1'b0;
            n_latched          = 1'b0;
            o_result.position  = dhd_pkg::POS_W'(1);
            o_result.event_res = dhd_pkg::EV_RESYNC;
        end else if ((is_header || r_sync) && is_full) begin
            // No room left: drop the byte and start over unsynchronized.
            n_count            = '0;
            n_sync             = 1'b0;
            n_last_hdr         = 1'b0;
            n_acc              = '0;
            n_len              = '0;
            n_err              = 1'b0;
            n_latched          = 1'b0;
            o_result.event_res = dhd_pkg::EV_OVERFLOW;
        end else if (is_header || r_sync) begin
            // Store the byte; the length field latches when its last digit is behind us.
            if (!is_header &&
                r_count == dhd_pkg::COUNT_W'(dhd_pkg::LENGTH_OFFSET +
                                            dhd_pkg::LENGTH_DIGITS)) begin
                n_len     = r_acc;
                n_latched = 1'b1;
            end
            if (in_field) begin
                n_acc = {r_acc[dhd_pkg::LEN_W-5:0], digit.value};
                if (!digit.ok) begin
                    n_err = 1'b1;
                end
            end
            n_count            = count_inc;
            n_last_hdr         = is_header;
            o_result.position  = r_count[dhd_pkg::POS_W-1:0];
            o_result.event_res = dhd_pkg::EV_STORE;
            o_result.body_length = n_len;
            o_result.bad_digit   = n_latched && n_err;
            done_sum = {1'b0, n_len} + dhd_pkg::LEN_SUM_W'(dhd_pkg::HEADER_SIZE);
            if (!is_header && done_sum == dhd_pkg::LEN_SUM_W'(count_inc)) begin
                // Last byte of the frame: report it, then start over.
                o_result.event_res = dhd_pkg::EV_DONE;
                n_count            = '0;
                n_sync             = 1'b0;
                n_last_hdr         = 1'b0;
                n_acc              = '0;
                n_len              = '0;
                n_err              = 1'b0;
                n_latched          = 1'b0;
            end
        end else begin
            // Unsynchronized non-header byte is dropped.
            o_result.body_length = r_len;
            o_result.bad_digit   = r_latched && r_err;
        end
    end

    // Parser state registers, updated on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sync     <= 1'b0;
            r_last_hdr <= 1'b0;
            r_acc      <= '0;
            r_len      <= '0;
            r_err      <= 1'b0;
            r_latched  <= 1'b0;
        end else if (i_accept) begin
            r_count    <= n_count;
            r_sync     <= n_sync;
            r_last_hdr <= n_last_hdr;
            r_acc      <= n_acc;
            r_len      <= n_len;
            r_err      <= n_err;
            r_latched  <= n_latched;
        end
    end

endmodule

>>> src/dhd_out_reg.sv
// Result register of the deframer: holds one result word toward the output stream.
// Depends on dhd_pkg for the result type.
module dhd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dhd_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_ready,
    output dhd_pkg::t_result o_result
);

    logic             r_valid;
    dhd_pkg::t_result r_result;

    // A new word may enter when the slot is empty or is being drained now.
    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, loaded on each accepted word.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

>>> src/double_header_hex_length_deframer_unit.sv
// Top level of the double-header hex-length deframer.
// Depends on dhd_pkg, dhd_parser and dhd_out_reg.

// The block takes one received byte per clock on the input stream and returns
// exactly one result word per byte, in the next cycle, from a single result
// register; throughput is one word per clock while the output side keeps up,
// and the input stalls only while that register holds a word not yet taken.
// The header byte is set through the configuration channel, which is always
// ready and should be written only while no word is in flight. Result tdata
// carries the echoed byte, its frame position, the latched body length and
// the bad-digit flag; tuser carries the event code.
module double_header_hex_length_deframer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: header byte value.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [7:0]                      i_cfg_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,    // [7:0] byte_in
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] byte_out, [17:8] position, [33:18] body_length, [34] bad_digit, rest zero
    output logic [dhd_pkg::RES_DATA_W-1:0] m_axis_tdata,
    output logic [dhd_pkg::EV_W-1:0]       m_axis_tuser      // [2:0] event_res
);

    logic [dhd_pkg::BYTE_W-1:0] r_header;
    logic                       in_accept;
    dhd_pkg::t_result           parse_res;
    dhd_pkg::t_result           out_res;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = s_axis_tvalid && s_axis_tready;

    // Header byte register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
        end else if (i_cfg_valid) begin
            r_header <= i_cfg_data;
        end
    end

    dhd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_header (r_header),
        .o_result (parse_res)
    );

    dhd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_result (parse_res),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    // Pack the result word onto the output stream.
    assign m_axis_tdata = {
        {(dhd_pkg::RES_DATA_W - dhd_pkg::RES_BITS){1'b0}},
        out_res.bad_digit,
        out_res.body_length,
        out_res.position,
        out_res.byte_out
    };
    assign m_axis_tuser = out_res.event_res;

    // A resync result always points at the second header.
    a_resync_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == dhd_pkg::EV_RESYNC) |->
            (m_axis_tdata[17:8] == 10'd1))
        else $error("resync result with position other than one");

    // Dropped and overflow results carry position zero.
    a_drop_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == dhd_pkg::EV_DROP ||
                           m_axis_tuser == dhd_pkg::EV_OVERFLOW)) |->
            (m_axis_tdata[17:8] == 10'd0))
        else $error("dropped or overflow result with nonzero position");

    // A stalled result blocks the input.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while result register is stalled");

    // An accepted byte always produces a result on the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted byte without a result");

endmodule

>>> tb/sv/dhd_checker.sv
// Result checker for the double-header hex-length deframer: predicts every output word
// from the accepted input bytes and header writes, and compares field by field.
// Depends on dhd_pkg for the field widths, frame constants and event codes.
module dhd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [dhd_pkg::RES_DATA_W-1:0] i_m_tdata,
    input  logic [dhd_pkg::EV_W-1:0]       i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);

    // Shadow copy of the parser state and the header register.
    logic [7:0]                  header_val;
    logic [dhd_pkg::COUNT_W-1:0] frame_count;
    logic                        in_sync;
    logic                        prev_was_header;
    logic [dhd_pkg::LEN_W-1:0]   len_accum;
    logic [dhd_pkg::LEN_W-1:0]   len_held;
    logic                        len_latched;
    logic                        digit_bad;

    // Words predicted but not yet seen on the output, oldest first.
    dhd_pkg::t_result predicted_words[$];
    dhd_pkg::t_result want_word;

    task automatic report_mismatch(input string field, input int got_v, input int want_v);
        $display("MISMATCH %s: got 0x%0h, predicted 0x%0h", field, got_v, want_v);
        o_fail_count = o_fail_count + 1;
    endtask

    // Returns the parser to its unsynchronized, empty state.
    task automatic clear_frame();
        frame_count     = '0;
        in_sync         = 1'b0;
        prev_was_header = 1'b0;
        len_accum       = '0;
        len_held        = '0;
        len_latched     = 1'b0;
        digit_bad       = 1'b0;
    endtask

    // Shifts a stored byte into the length accumulator when it sits in the length field.
    task automatic take_digit(input logic [dhd_pkg::COUNT_W-1:0] pos, input logic [7:0] b);
        logic [7:0] diff;
        logic [3:0] nib;
        diff = 8'h00;
        if (pos >= dhd_pkg::LENGTH_OFFSET &&
            pos < dhd_pkg::LENGTH_OFFSET + dhd_pkg::LENGTH_DIGITS) begin
            if (b >= 8'h30 && b <= 8'h39) begin
                diff = b - 8'h30;
            end else if (b >= 8'h41 && b <= 8'h46) begin
                diff = b - 8'h41 + 8'd10;
            end else if (b >= 8'h61 && b <= 8'h66) begin
                diff = b - 8'h61 + 8'd10;
            end else begin
                digit_bad = 1'b1;
            end
            nib       = diff[3:0];
            len_accum = {len_accum[dhd_pkg::LEN_W-5:0], nib};
        end
    endtask

    // Advances the shadow parser by one received byte and builds the word it yields.
    task automatic deframe_byte(input logic [7:0] b, output dhd_pkg::t_result r);
        dhd_pkg::t_event           ev;
        logic [dhd_pkg::POS_W-1:0] pos;
        ev  = dhd_pkg::EV_DROP;
        pos = '0;
        if (b == header_val) begin
            if (prev_was_header) begin
                clear_frame();
                frame_count     = dhd_pkg::COUNT_W'(2);
                in_sync         = 1'b1;
                prev_was_header = 1'b1;
                pos             = dhd_pkg::POS_W'(1);
                ev              = dhd_pkg::EV_RESYNC;
            end else if (frame_count >= dhd_pkg::MAX_FRAME) begin
                clear_frame();
                ev = dhd_pkg::EV_OVERFLOW;
            end else begin
                pos = frame_count[dhd_pkg::POS_W-1:0];
                take_digit(frame_count, b);
                frame_count     = frame_count + 1'b1;
                prev_was_header = 1'b1;
                ev              = dhd_pkg::EV_STORE;
            end
        end else if (in_sync) begin
            if (frame_count >= dhd_pkg::MAX_FRAME) begin
                clear_frame();
                ev = dhd_pkg::EV_OVERFLOW;
            end else begin
                if (frame_count == dhd_pkg::LENGTH_OFFSET + dhd_pkg::LENGTH_DIGITS) begin
                    len_held    = len_accum;
                    len_latched = 1'b1;
                end
                pos = frame_count[dhd_pkg::POS_W-1:0];
                take_digit(frame_count, b);
                frame_count     = frame_count + 1'b1;
                prev_was_header = 1'b0;
                ev              = dhd_pkg::EV_STORE;
                if (int'(len_held) + dhd_pkg::HEADER_SIZE == int'(frame_count)) begin
                    ev = dhd_pkg::EV_DONE;
                end
            end
        end
        r.byte_out    = b;
        r.position    = pos;
        r.event_res   = ev;
        r.body_length = len_held;
        r.bad_digit   = len_latched && digit_bad;
        if (ev == dhd_pkg::EV_DONE) begin
            clear_frame();
        end
    endtask

    // Compare first, so a word leaving at the same edge as a byte enters matches older data.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            header_val = 8'h00;
            clear_frame();
            predicted_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_words.size() == 0) begin
                    report_mismatch("word with no prediction",
                                    int'(i_m_tdata[dhd_pkg::BYTE_W-1:0]), 0);
                end else begin
                    want_word = predicted_words.pop_front();
                    if (i_m_tdata[dhd_pkg::BYTE_W-1:0] !== want_word.byte_out)
                        report_mismatch("byte_out", int'(i_m_tdata[dhd_pkg::BYTE_W-1:0]),
                                        int'(want_word.byte_out));
                    if (i_m_tdata[dhd_pkg::BYTE_W +: dhd_pkg::POS_W] !== want_word.position)
                        report_mismatch("position",
                                        int'(i_m_tdata[dhd_pkg::BYTE_W +: dhd_pkg::POS_W]),
                                        int'(want_word.position));
                    if (i_m_tdata[dhd_pkg::BYTE_W+dhd_pkg::POS_W +: dhd_pkg::LEN_W] !==
                        want_word.body_length)
                        report_mismatch("body_length",
                            int'(i_m_tdata[dhd_pkg::BYTE_W+dhd_pkg::POS_W +: dhd_pkg::LEN_W]),
                            int'(want_word.body_length));
                    if (i_m_tdata[dhd_pkg::RES_BITS-1] !== want_word.bad_digit)
                        report_mismatch("bad_digit", int'(i_m_tdata[dhd_pkg::RES_BITS-1]),
                                        int'(want_word.bad_digit));
                    if (i_m_tdata[dhd_pkg::RES_DATA_W-1:dhd_pkg::RES_BITS] !== '0)
                        report_mismatch("tdata padding",
                            int'(i_m_tdata[dhd_pkg::RES_DATA_W-1:dhd_pkg::RES_BITS]), 0);
                    if (i_m_tuser !== want_word.event_res)
                        report_mismatch("event_res", int'(i_m_tuser), int'(want_word.event_res));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                header_val = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                deframe_byte(i_s_tdata, want_word);
                predicted_words.push_back(want_word);
            end
        end
        o_pending = predicted_words.size();
    end

endmodule

>>> tb/sv/tb_double_header_hex_length_deframer_unit.sv
// Top of the deframer testbench: clock, reset, byte stimulus, header writes and output stalls.
// Depends on dhd_pkg, double_header_hex_length_deframer_unit and dhd_checker.
module tb_double_header_hex_length_deframer_unit;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_CYCLIC} t_rx_mode;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [7:0]                     cfg_data  = 8'h00;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = 8'h00;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [dhd_pkg::RES_DATA_W-1:0] m_tdata;
    logic [dhd_pkg::EV_W-1:0]       m_tuser;
    int                             fail_count;
    int                             pending;

    logic [7:0] cur_header = 8'h00;
    int         burst_left = 0;
    int         bytes_sent = 0;
    int         phase_end;
    t_rx_mode   rx_mode    = RX_FREE;
    int         rx_left    = 0;
    int         rx_tick    = 0;

    double_header_hex_length_deframer_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    dhd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side stalls in segments, each with its own ready pattern.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end
        rx_left = rx_left - 1;
        rx_tick = rx_tick + 1;
        case (rx_mode)
            RX_FREE: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= ((rx_tick % 5) < 3);
            end
        endcase
    end

    // Sends one byte, inserting a random gap at the end of each burst.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 250))
                                                     : int'($urandom_range(1, 24));
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left = burst_left - 1;
        bytes_sent = bytes_sent + 1;
    endtask

    // Holds the input back until every predicted word has come out.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_header(input logic [7:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid  = 1'b0;
        cur_header = value;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return (lower ? 8'h61 : 8'h41) + nib - 4'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 5))
            0: return 8'h2F;
            1: return 8'h3A;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h67;
            default: return 8'h80 | 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Sends a frame with a doubled header, a hex length field and a random body.
    // A non-negative cut stops it after that many bytes; clean keeps the header out of the body.
    task automatic send_frame(input int body_len, input bit bad, input bit lower,
                              input int cut, input bit clean);
        logic [7:0] b;
        logic [15:0] len16;
        int          bad_at;
        int          idx;
        int          total;
        len16  = 16'(body_len);
        bad_at = bad ? int'($urandom_range(0, dhd_pkg::LENGTH_DIGITS - 1)) : -1;
        total  = body_len + dhd_pkg::HEADER_SIZE;
        if (cut >= 0 && cut < total)
            total = cut;
        for (idx = 0; idx < total; idx++) begin
            if (idx < 2) begin
                b = cur_header;
            end else if (idx < dhd_pkg::LENGTH_OFFSET + dhd_pkg::LENGTH_DIGITS) begin
                if (idx - dhd_pkg::LENGTH_OFFSET == bad_at)
                    b = non_hex_char();
                else
                    b = hex_char(len16[4*(dhd_pkg::LENGTH_OFFSET+dhd_pkg::LENGTH_DIGITS-1-idx)
                                       +: 4], lower);
            end else begin
                b = 8'($urandom_range(0, 255));
                if (!clean && $urandom_range(0, 39) == 0)
                    b = cur_header;
                if (clean && b == cur_header)
                    b = b ^ 8'h01;
            end
            send_byte(b);
        end
    endtask

    // Mostly well-formed frames with random content; the rest is noise and broken starts.
    task automatic random_traffic(input int count);
        int pick;
        int len;
        int n;
        phase_end = bytes_sent + count;
        while (bytes_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                n = $urandom_range(0, 99);
                if (n < 70)
                    len = $urandom_range(0, 12);
                else if (n < 95)
                    len = $urandom_range(13, 60);
                else
                    len = $urandom_range(61, 300);
                send_frame(len, $urandom_range(0, 9) == 0, $urandom_range(0, 1) == 1,
                           ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, len + 8)) : -1,
                           1'b0);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(($urandom_range(0, 3) == 0) ? cur_header : 8'($urandom));
                end
            end else if (pick < 92) begin
                repeat (3) send_byte(cur_header);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(cur_header);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(cur_header);
                send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end
    endtask

    // Reset, directed cases, then random phases under several header values.
    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset header value of zero: a dropped byte, a lone header, then a resync.
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h31);

        // Short frame with a two-byte body, ending on the last body byte.
        write_header(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h30);
        send_byte(8'h30);
        send_byte(8'h30);
        send_byte(8'h32);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);

        // A header in the latch slot skips the latch, so the frame ends at the header size.
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h30);
        send_byte(8'h30);
        send_byte(8'h30);
        send_byte(8'h30);
        send_byte(8'h7E);
        send_byte(8'h5A);

        random_traffic(120);

        // Header of zero, with a frame that fills up and then meets a single header.
        write_header(8'h00);
        send_frame(2000, 1'b0, 1'b0, dhd_pkg::MAX_FRAME, 1'b1);
        send_byte(cur_header);
        random_traffic(60);

        write_header(8'hFF);
        random_traffic(60);

        write_header(8'($urandom_range(0, 255)));
        random_traffic(60);

        write_header(8'($urandom_range(0, 255)));
        random_traffic(60);

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Run limit far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
